// ===== rtl/ipdps_pkg.sv =====
// Shared types, constants and helper functions for the induction pan
// detection power sequencer. No dependencies.
package ipdps_pkg;

  localparam int unsigned DutyW   = 7;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned TempW   = 10;
  localparam int unsigned CountW  = 8;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned MarkW   = 2;

  // Duty applied whenever coil current has not been proven.
  localparam logic [DutyW-1:0] MIN_DUTY = 7'd5;
  localparam logic [DutyW-1:0] MAX_DUTY = 7'd100;

  // Probe ownership marks.
  localparam logic [MarkW-1:0] PROBE_UNVERIFIED = 2'd0;
  localparam logic [MarkW-1:0] PROBE_IDLE       = 2'd1;
  localparam logic [MarkW-1:0] PROBE_ACTIVE     = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COIL_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_SWITCH_LIMIT = 3'd1;
  localparam logic [2:0] CFG_COIL_HYST    = 3'd2;
  localparam logic [2:0] CFG_SWITCH_HYST  = 3'd3;
  localparam logic [2:0] CFG_LOW_CUR_LIM  = 3'd4;
  localparam logic [2:0] CFG_PAN_MIN      = 3'd5;
  localparam logic [2:0] CFG_PAN_MAX      = 3'd6;
  localparam logic [2:0] CFG_FREQ_MIN     = 3'd7;

  // Sequencer phases.
  localparam logic [PhaseW-1:0] PH_ENABLE_CHECK = 4'd0;
  localparam logic [PhaseW-1:0] PH_SETTLE       = 4'd1;
  localparam logic [PhaseW-1:0] PH_CURRENT_CHK  = 4'd2;
  localparam logic [PhaseW-1:0] PH_PROBE_START  = 4'd3;
  localparam logic [PhaseW-1:0] PH_PAN_DRIVE    = 4'd4;
  localparam logic [PhaseW-1:0] PH_PAN_FIRE     = 4'd5;
  localparam logic [PhaseW-1:0] PH_PAN_CHECK    = 4'd6;
  localparam logic [PhaseW-1:0] PH_FREQ_DRIVE   = 4'd7;
  localparam logic [PhaseW-1:0] PH_FREQ_FIRE    = 4'd8;
  localparam logic [PhaseW-1:0] PH_FREQ_CHECK   = 4'd9;

  // Per-channel supervisor state.
  typedef struct packed {
    logic [PhaseW-1:0] seq_phase;
    logic [DutyW-1:0]  applied_duty;
    logic [IndexW-1:0] table_index;
    logic              hot_flag;
    logic              pan_flag;
    logic              freq_flag;
    logic              current_ok;
    logic [CountW-1:0] low_count;
    logic [MarkW-1:0]  probe_mark;
    logic              drive_level;
  } chan_state_t;

  // Minimum expected coil current for a duty band; indexes past the end
  // saturate to the last entry.
  function automatic logic [CountW-1:0] min_current(input logic [IndexW-1:0] idx);
    logic [CountW-1:0] val;
    case (idx)
      4'd0:    val = 8'd2;
      4'd1:    val = 8'd2;
      4'd2:    val = 8'd10;
      4'd3:    val = 8'd18;
      4'd4:    val = 8'd30;
      4'd5:    val = 8'd40;
      4'd6:    val = 8'd50;
      4'd7:    val = 8'd65;
      default: val = 8'd80;
    endcase
    return val;
  endfunction

  // Duty divided by ten: multiply by 103/1024, exact for every 7-bit value.
  function automatic logic [IndexW-1:0] duty_div10(input logic [DutyW-1:0] d);
    logic [13:0] prod;
    prod = 14'(d) * 14'd103;
    return prod[13:10];
  endfunction

endpackage

// ===== rtl/induction_pan_detect_power_sequencer.sv =====
// Top level of the two-channel induction coil supervisor with pan detection.
// Depends on ipdps_pkg for the channel state type, table and constants.
//
//  Channel   Direction  Handshake                        Payload
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o  tdata 48b, tuser 2b
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i  tdata 16b
//  cfg       in         cfg_we_i                         cfg_idx_i, cfg_wdata_i
//
// One transaction is taken per clock cycle while input is not refused; each
// produces one result, passing through the input register, then the result
// register. The channel state is updated as an item moves from the input
// register into the result register, so items for the same channel may
// follow each other in consecutive cycles. rst_ni clears all channel state
// and loads the register defaults. A stalled result register holds the input
// register, and input is refused only when both stages are full.
module induction_pan_detect_power_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input transaction.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: enable, target_duty[6:0], coil_temp[9:0], switch_temp[9:0],
  // coil_current[7:0], pulse_count[7:0], four zero bits.
  input  logic [47:0] s_axis_tdata_i,
  // From bit 0: action, channel.
  input  logic [1:0]  s_axis_tuser_i,
  // Result transaction.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: duty[6:0], coil_on, fire_pulse, overtemp, pan_found,
  // freq_found, phase[3:0].
  output logic [15:0] m_axis_tdata_o,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i
);

  // Configuration registers.
  logic [9:0] coil_lim_q, switch_lim_q, coil_hyst_q, switch_hyst_q;
  logic [7:0] low_cur_lim_q, pan_min_q, pan_max_q, freq_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coil_lim_q    <= 10'd800;
      switch_lim_q  <= 10'd800;
      coil_hyst_q   <= 10'd50;
      switch_hyst_q <= 10'd50;
      low_cur_lim_q <= 8'd3;
      pan_min_q     <= 8'd3;
      pan_max_q     <= 8'd20;
      freq_min_q    <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipdps_pkg::CFG_COIL_LIMIT:   coil_lim_q    <= cfg_wdata_i;
        ipdps_pkg::CFG_SWITCH_LIMIT: switch_lim_q  <= cfg_wdata_i;
        ipdps_pkg::CFG_COIL_HYST:    coil_hyst_q   <= cfg_wdata_i;
        ipdps_pkg::CFG_SWITCH_HYST:  switch_hyst_q <= cfg_wdata_i;
        ipdps_pkg::CFG_LOW_CUR_LIM:  low_cur_lim_q <= cfg_wdata_i[7:0];
        ipdps_pkg::CFG_PAN_MIN:      pan_min_q     <= cfg_wdata_i[7:0];
        ipdps_pkg::CFG_PAN_MAX:      pan_max_q     <= cfg_wdata_i[7:0];
        ipdps_pkg::CFG_FREQ_MIN:     freq_min_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register stage. The payload needs no reset.
  logic        in_valid_q;
  logic        act_q, ch_q, en_q;
  logic [6:0]  target_q;
  logic [9:0]  coil_temp_q, switch_temp_q;
  logic [7:0]  current_q, pulses_q;

  // Result register stage.
  logic        out_valid_q;
  logic [15:0] out_data_q;

  logic out_free, advance, in_take;

  // The result register can take a new result when empty or being drained.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q         <= s_axis_tuser_i[0];
      ch_q          <= s_axis_tuser_i[1];
      en_q          <= s_axis_tdata_i[0];
      target_q      <= s_axis_tdata_i[7:1];
      coil_temp_q   <= s_axis_tdata_i[17:8];
      switch_temp_q <= s_axis_tdata_i[27:18];
      current_q     <= s_axis_tdata_i[35:28];
      pulses_q      <= s_axis_tdata_i[43:36];
    end
  end

  // Channel state.
  ipdps_pkg::chan_state_t chan_q [2];
  ipdps_pkg::chan_state_t cur_st, nxt_st;
  logic [1:0] other_mark;
  logic       fire;

  assign cur_st     = ch_q ? chan_q[1] : chan_q[0];
  assign other_mark = ch_q ? chan_q[0].probe_mark : chan_q[1].probe_mark;

  // Hysteresis thresholds may go negative, so compare as signed values.
  logic signed [11:0] coil_clr_thr, switch_clr_thr, coil_t_s, switch_t_s;
  assign coil_clr_thr   = $signed({2'b00, coil_lim_q}) - $signed({2'b00, coil_hyst_q});
  assign switch_clr_thr = $signed({2'b00, switch_lim_q}) - $signed({2'b00, switch_hyst_q});
  assign coil_t_s       = $signed({2'b00, coil_temp_q});
  assign switch_t_s     = $signed({2'b00, switch_temp_q});

  always_comb begin
    logic [6:0] target_sat;
    logic       low_current;
    nxt_st      = cur_st;
    fire        = 1'b0;
    target_sat  = (target_q > ipdps_pkg::MAX_DUTY) ? ipdps_pkg::MAX_DUTY : target_q;
    low_current = current_q < ipdps_pkg::min_current(cur_st.table_index);

    if (!act_q) begin
      // Fast tick: latch the duty band before ramping, then ramp (or drop to the
      // minimum duty while current is unproven) and check temperatures.
      nxt_st.table_index = ipdps_pkg::duty_div10(cur_st.applied_duty);
      if (cur_st.current_ok) begin
        if (cur_st.applied_duty < target_sat) begin
          nxt_st.applied_duty = cur_st.applied_duty + 7'd1;
        end else if (cur_st.applied_duty > target_sat) begin
          nxt_st.applied_duty = cur_st.applied_duty - 7'd1;
        end
      end else begin
        nxt_st.applied_duty = ipdps_pkg::MIN_DUTY;
      end
      if (coil_temp_q > coil_lim_q || switch_temp_q > switch_lim_q) begin
        nxt_st.hot_flag = 1'b1;
      end else if (coil_t_s < coil_clr_thr && switch_t_s < switch_clr_thr) begin
        nxt_st.hot_flag = 1'b0;
      end
    end else begin
      case (cur_st.seq_phase)
        ipdps_pkg::PH_ENABLE_CHECK: begin
          if (en_q && !cur_st.hot_flag) begin
            nxt_st.drive_level = 1'b1;
            nxt_st.seq_phase   = ipdps_pkg::PH_SETTLE;
            nxt_st.probe_mark  = (cur_st.freq_flag && cur_st.pan_flag && cur_st.current_ok)
                               ? ipdps_pkg::PROBE_IDLE : ipdps_pkg::PROBE_UNVERIFIED;
          end else begin
            nxt_st.applied_duty = ipdps_pkg::MIN_DUTY;
            nxt_st.freq_flag    = 1'b0;
            nxt_st.pan_flag     = 1'b0;
            nxt_st.current_ok   = 1'b0;
            nxt_st.drive_level  = 1'b0;
            nxt_st.seq_phase    = ipdps_pkg::PH_ENABLE_CHECK;
            nxt_st.probe_mark   = ipdps_pkg::PROBE_IDLE;
          end
        end
        ipdps_pkg::PH_SETTLE: nxt_st.seq_phase = ipdps_pkg::PH_CURRENT_CHK;
        ipdps_pkg::PH_CURRENT_CHK: begin
          if (low_current) begin
            if (cur_st.low_count < low_cur_lim_q) begin
              nxt_st.low_count = cur_st.low_count + 8'd1;
            end else begin
              nxt_st.low_count    = '0;
              nxt_st.applied_duty = ipdps_pkg::MIN_DUTY;
              nxt_st.freq_flag    = 1'b0;
              nxt_st.pan_flag     = 1'b0;
              nxt_st.current_ok   = 1'b0;
              nxt_st.drive_level  = 1'b0;
              // Only one channel may own the probe at a time.
              if (other_mark != ipdps_pkg::PROBE_ACTIVE) begin
                nxt_st.seq_phase  = ipdps_pkg::PH_PROBE_START;
                nxt_st.probe_mark = ipdps_pkg::PROBE_ACTIVE;
              end else begin
                nxt_st.seq_phase  = ipdps_pkg::PH_ENABLE_CHECK;
              end
            end
          end else begin
            nxt_st.current_ok = 1'b1;
            nxt_st.freq_flag  = 1'b1;
            nxt_st.pan_flag   = 1'b1;
            nxt_st.low_count  = '0;
            nxt_st.seq_phase  = ipdps_pkg::PH_ENABLE_CHECK;
          end
        end
        ipdps_pkg::PH_PROBE_START: nxt_st.seq_phase = ipdps_pkg::PH_PAN_DRIVE;
        ipdps_pkg::PH_PAN_DRIVE: begin
          nxt_st.drive_level = 1'b1;
          nxt_st.seq_phase   = ipdps_pkg::PH_PAN_FIRE;
        end
        ipdps_pkg::PH_PAN_FIRE: begin
          fire               = 1'b1;
          nxt_st.drive_level = 1'b0;
          nxt_st.seq_phase   = ipdps_pkg::PH_PAN_CHECK;
        end
        ipdps_pkg::PH_PAN_CHECK: begin
          if (pulses_q < pan_min_q || pulses_q > pan_max_q) begin
            nxt_st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
            nxt_st.pan_flag  = 1'b0;
          end else begin
            nxt_st.seq_phase = ipdps_pkg::PH_FREQ_DRIVE;
            nxt_st.pan_flag  = 1'b1;
          end
        end
        ipdps_pkg::PH_FREQ_DRIVE: begin
          nxt_st.drive_level = 1'b1;
          nxt_st.seq_phase   = ipdps_pkg::PH_FREQ_FIRE;
        end
        ipdps_pkg::PH_FREQ_FIRE: begin
          fire             = 1'b1;
          nxt_st.seq_phase = ipdps_pkg::PH_FREQ_CHECK;
        end
        ipdps_pkg::PH_FREQ_CHECK: begin
          nxt_st.freq_flag = (pulses_q >= freq_min_q);
          nxt_st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
        end
        // Phase codes outside the sequence return to the enable check.
        default: nxt_st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q[0] <= '0;
      chan_q[1] <= '0;
    end else if (advance) begin
      if (ch_q) begin
        chan_q[1] <= nxt_st;
      end else begin
        chan_q[0] <= nxt_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {nxt_st.seq_phase, nxt_st.freq_flag, nxt_st.pan_flag,
                     nxt_st.hot_flag, fire, nxt_st.drive_level, nxt_st.applied_duty};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // A start pulse is only ever fired by a slow tick.
  a_fire_only_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !act_q) |=> !out_data_q[8])
    else $error("fire_pulse raised by a fast tick");

  // The probe lock never lets both channels probe together.
  a_probe_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chan_q[0].probe_mark == ipdps_pkg::PROBE_ACTIVE &&
      chan_q[1].probe_mark == ipdps_pkg::PROBE_ACTIVE))
    else $error("both channels hold the probe");

  // Applied duty stays within the saturated range on both channels.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q[0].applied_duty <= ipdps_pkg::MAX_DUTY &&
    chan_q[1].applied_duty <= ipdps_pkg::MAX_DUTY)
    else $error("applied duty above maximum");

  // A delivered result always reports a phase inside the sequence.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[15:12] <= ipdps_pkg::PH_FREQ_CHECK)
    else $error("result phase outside the sequence");
`endif

endmodule

// ===== tb/induction_pan_detect_power_sequencer_test.sv =====
// Self-checking testbench for the two-channel induction coil supervisor.
// Depends on ipdps_pkg and the induction_pan_detect_power_sequencer RTL only.
`timescale 1ns / 100ps

module induction_pan_detect_power_sequencer_test;

  // Tick kinds carried in tuser bit 0.
  typedef enum logic {
    FAST_TICK = 1'b0,
    SLOW_TICK = 1'b1
  } tick_kind_e;

  // One input transaction, laid out exactly as {tuser, tdata} on the pins.
  typedef struct packed {
    logic                        channel;
    logic                        action;
    logic [3:0]                  pad;
    logic [7:0]                  pulses;
    logic [7:0]                  amps;
    logic [ipdps_pkg::TempW-1:0] switch_temp;
    logic [ipdps_pkg::TempW-1:0] coil_temp;
    logic [ipdps_pkg::DutyW-1:0] target;
    logic                        enable;
  } tick_t;

  // One result transaction, laid out exactly as tdata on the pins.
  typedef struct packed {
    logic [ipdps_pkg::PhaseW-1:0] phase;
    logic                         freq_found;
    logic                         pan_found;
    logic                         overtemp;
    logic                         fire_pulse;
    logic                         coil_on;
    logic [ipdps_pkg::DutyW-1:0]  duty;
  } status_t;

  // Minimum coil current per duty band of ten percent; entry 0 is rightmost.
  localparam logic [10:0][7:0] MIN_AMPS = {8'd80, 8'd80, 8'd80, 8'd65, 8'd50,
                                           8'd40, 8'd30, 8'd18, 8'd10, 8'd2, 8'd2};

  // ---------------------------------------------------------------------------
  // Pins. Every input of the block starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // From bit 0: enable, target_duty[6:0], coil_temp[9:0], switch_temp[9:0],
  // coil_current[7:0], pulse_count[7:0], four zero bits.
  logic [47:0] s_axis_tdata_i = '0;
  // From bit 0: action, channel.
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // From bit 0: duty[6:0], coil_on, fire_pulse, overtemp, pan_found,
  // freq_found, phase[3:0].
  logic [15:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_wdata_i = '0;

  induction_pan_detect_power_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Testbench state.
  // ---------------------------------------------------------------------------
  tick_t                  ticks_to_send[$];     // stimulus not yet presented
  status_t                expected_status[$];   // predicted results, oldest first
  ipdps_pkg::chan_state_t coil_state [2];       // predictor's copy of each channel
  logic [9:0]             reg_copy [0:7];       // predictor's copy of the registers
  int          failures = 0;
  int          items_accepted = 0;
  bit          in_taken = 1'b0;      // input transaction completed at last edge
  bit          sender_idling = 1'b0;
  bit          recv_idling = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_at = 32'h7fff_ffff;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // 2 ns clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #400000;
    $display("induction_pan_detect_power_sequencer_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  // Everything a channel gives up when it stops driving the coil.
  function automatic ipdps_pkg::chan_state_t power_down(ipdps_pkg::chan_state_t s);
    s.applied_duty = ipdps_pkg::MIN_DUTY;
    s.freq_flag    = 1'b0;
    s.pan_flag     = 1'b0;
    s.current_ok   = 1'b0;
    s.drive_level  = 1'b0;
    return s;
  endfunction

  // Advances the addressed channel by one tick and returns the status word
  // that the block should report for it.
  function automatic status_t supervise_tick(tick_t t);
    ipdps_pkg::chan_state_t      st;
    logic [ipdps_pkg::MarkW-1:0] peer_mark;
    logic [ipdps_pkg::DutyW-1:0] goal;
    logic [3:0]                  band;
    int                          coil_t;
    int                          sw_t;
    status_t                     r;
    st        = coil_state[t.channel];
    peer_mark = coil_state[!t.channel].probe_mark;
    r.fire_pulse = 1'b0;
    if (t.action == FAST_TICK) begin
      goal = (t.target > ipdps_pkg::MAX_DUTY) ? ipdps_pkg::MAX_DUTY : t.target;
      // The band is taken from the duty before this tick's ramp step.
      st.table_index = 4'(st.applied_duty / 7'd10);
      if (st.current_ok) begin
        if (st.applied_duty < goal) begin
          st.applied_duty = st.applied_duty + 1'b1;
        end else if (st.applied_duty > goal) begin
          st.applied_duty = st.applied_duty - 1'b1;
        end
      end else begin
        st.applied_duty = ipdps_pkg::MIN_DUTY;
      end
      // Hysteresis: set above either limit, clear only when both are below
      // their limit minus hysteresis, which may go negative.
      coil_t = int'(t.coil_temp);
      sw_t   = int'(t.switch_temp);
      if (coil_t > int'(reg_copy[ipdps_pkg::CFG_COIL_LIMIT]) ||
          sw_t > int'(reg_copy[ipdps_pkg::CFG_SWITCH_LIMIT])) begin
        st.hot_flag = 1'b1;
      end else if (coil_t < int'(reg_copy[ipdps_pkg::CFG_COIL_LIMIT]) -
                            int'(reg_copy[ipdps_pkg::CFG_COIL_HYST]) &&
                   sw_t < int'(reg_copy[ipdps_pkg::CFG_SWITCH_LIMIT]) -
                          int'(reg_copy[ipdps_pkg::CFG_SWITCH_HYST])) begin
        st.hot_flag = 1'b0;
      end
    end else begin
      case (st.seq_phase)
        ipdps_pkg::PH_ENABLE_CHECK: begin
          if (t.enable && !st.hot_flag) begin
            st.drive_level = 1'b1;
            st.seq_phase   = ipdps_pkg::PH_SETTLE;
            st.probe_mark  = (st.freq_flag && st.pan_flag && st.current_ok) ?
                             ipdps_pkg::PROBE_IDLE : ipdps_pkg::PROBE_UNVERIFIED;
          end else begin
            st            = power_down(st);
            st.seq_phase  = ipdps_pkg::PH_ENABLE_CHECK;
            st.probe_mark = ipdps_pkg::PROBE_IDLE;
          end
        end
        ipdps_pkg::PH_SETTLE: st.seq_phase = ipdps_pkg::PH_CURRENT_CHK;
        ipdps_pkg::PH_CURRENT_CHK: begin
          band = (st.table_index > 4'd10) ? 4'd10 : st.table_index;
          if (t.amps < MIN_AMPS[band]) begin
            if (st.low_count < reg_copy[ipdps_pkg::CFG_LOW_CUR_LIM][7:0]) begin
              st.low_count = st.low_count + 1'b1;
            end else begin
              st.low_count = '0;
              st = power_down(st);
              // Only one channel may own the probe sequence at a time.
              if (peer_mark != ipdps_pkg::PROBE_ACTIVE) begin
                st.seq_phase  = ipdps_pkg::PH_PROBE_START;
                st.probe_mark = ipdps_pkg::PROBE_ACTIVE;
              end else begin
                st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
              end
            end
          end else begin
            st.current_ok = 1'b1;
            st.freq_flag  = 1'b1;
            st.pan_flag   = 1'b1;
            st.low_count  = '0;
            st.seq_phase  = ipdps_pkg::PH_ENABLE_CHECK;
          end
        end
        ipdps_pkg::PH_PROBE_START: st.seq_phase = ipdps_pkg::PH_PAN_DRIVE;
        ipdps_pkg::PH_PAN_DRIVE: begin
          st.drive_level = 1'b1;
          st.seq_phase   = ipdps_pkg::PH_PAN_FIRE;
        end
        ipdps_pkg::PH_PAN_FIRE: begin
          r.fire_pulse   = 1'b1;
          st.drive_level = 1'b0;
          st.seq_phase   = ipdps_pkg::PH_PAN_CHECK;
        end
        ipdps_pkg::PH_PAN_CHECK: begin
          if (t.pulses < reg_copy[ipdps_pkg::CFG_PAN_MIN][7:0] ||
              t.pulses > reg_copy[ipdps_pkg::CFG_PAN_MAX][7:0]) begin
            st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
            st.pan_flag  = 1'b0;
          end else begin
            st.seq_phase = ipdps_pkg::PH_FREQ_DRIVE;
            st.pan_flag  = 1'b1;
          end
        end
        ipdps_pkg::PH_FREQ_DRIVE: begin
          st.drive_level = 1'b1;
          st.seq_phase   = ipdps_pkg::PH_FREQ_FIRE;
        end
        ipdps_pkg::PH_FREQ_FIRE: begin
          r.fire_pulse = 1'b1;
          st.seq_phase = ipdps_pkg::PH_FREQ_CHECK;
        end
        ipdps_pkg::PH_FREQ_CHECK: begin
          st.freq_flag = (t.pulses >= reg_copy[ipdps_pkg::CFG_FREQ_MIN][7:0]);
          st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
        end
        default: st.seq_phase = ipdps_pkg::PH_ENABLE_CHECK;
      endcase
    end
    coil_state[t.channel] = st;
    r.duty       = st.applied_duty;
    r.coil_on    = st.drive_level;
    r.overtemp   = st.hot_flag;
    r.pan_found  = st.pan_flag;
    r.freq_found = st.freq_flag;
    r.phase      = st.seq_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic tick_t make_tick(tick_kind_e kind, logic ch, logic en,
                                      logic [6:0] tgt, logic [9:0] ctemp,
                                      logic [9:0] stemp, logic [7:0] amps,
                                      logic [7:0] pulses);
    tick_t t;
    t.channel     = ch;
    t.action      = kind;
    t.pad         = '0;
    t.pulses      = pulses;
    t.amps        = amps;
    t.switch_temp = stemp;
    t.coil_temp   = ctemp;
    t.target      = tgt;
    t.enable      = en;
    return t;
  endfunction

  // A tidy tick mostly has the coil enabled and cool temperatures, a current on
  // the chosen side of the table and pulse counts near the detect windows.
  // An untidy tick is pure noise over the full range of every field but the pad.
  function automatic tick_t random_tick(tick_kind_e kind, logic ch, bit tidy,
                                        bit low_amps);
    tick_t t;
    if (!tidy) begin
      t = make_tick(tick_kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      t = make_tick(kind, ch, ($urandom_range(0, 19) != 0),
                    ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                : 7'($urandom_range(0, 100)),
                    ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 600)),
                    ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 600)),
                    8'(0), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 30)));
      if (low_amps) begin
        t.amps = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 79))
                                             : 8'($urandom_range(0, 1));
      end else begin
        t.amps = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
                                             : 8'($urandom_range(80, 255));
      end
    end
    return t;
  endfunction

  // Queues roughly the given number of ticks, mostly as runs on one channel
  // that walk the sequencer, some long duty ramps, and some noise.
  task automatic queue_random(int count);
    int    queued;
    int    len;
    logic  ch;
    bit    low;
    tick_t t;
    queued = 0;
    while (queued < count) begin
      ch  = 1'($urandom_range(0, 1));
      low = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 4);
          repeat (len) ticks_to_send.push_back(random_tick(FAST_TICK, ch, 1'b0, 1'b0));
        end
        2: begin
          // Long ramp toward a high target with proven current, so the duty
          // reaches the top bands of the current table.
          len = $urandom_range(40, 130);
          repeat (len) begin
            if ($urandom_range(0, 4) == 0) begin
              t = random_tick(SLOW_TICK, ch, 1'b1, 1'b0);
            end else begin
              t = random_tick(FAST_TICK, ch, 1'b1, 1'b0);
              t.target = 7'($urandom_range(95, 127));
            end
            ticks_to_send.push_back(t);
          end
        end
        default: begin
          len = $urandom_range(4, 14);
          repeat (len) begin
            ticks_to_send.push_back(random_tick(
                ($urandom_range(0, 3) != 0) ? SLOW_TICK : FAST_TICK,
                ($urandom_range(0, 6) == 0) ? !ch : ch, 1'b1, low));
          end
        end
      endcase
      queued += len;
    end
  endtask

  // Register writes happen only while the block is idle; the predictor's
  // copy follows at the same moment.
  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    reg_copy[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(logic [9:0] coil_lim, logic [9:0] sw_lim,
                                logic [9:0] coil_hy, logic [9:0] sw_hy,
                                logic [7:0] low_lim, logic [7:0] pan_lo,
                                logic [7:0] pan_hi, logic [7:0] freq_lo);
    write_reg(ipdps_pkg::CFG_COIL_LIMIT, coil_lim);
    write_reg(ipdps_pkg::CFG_SWITCH_LIMIT, sw_lim);
    write_reg(ipdps_pkg::CFG_COIL_HYST, coil_hy);
    write_reg(ipdps_pkg::CFG_SWITCH_HYST, sw_hy);
    write_reg(ipdps_pkg::CFG_LOW_CUR_LIM, {2'b00, low_lim});
    write_reg(ipdps_pkg::CFG_PAN_MIN, {2'b00, pan_lo});
    write_reg(ipdps_pkg::CFG_PAN_MAX, {2'b00, pan_hi});
    write_reg(ipdps_pkg::CFG_FREQ_MIN, {2'b00, freq_lo});
  endtask

  // Waits until every queued tick has been taken and every result checked,
  // then lets the two pipeline stages settle.
  task automatic drain_block();
    wait (ticks_to_send.size() == 0);
    @(negedge clk_i);
    while (s_axis_tvalid_i || expected_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Reports one mismatching field of a result.
  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued ticks on the input side. A new tick is loaded
  // only when the slot is empty or its transaction completed at the last
  // rising edge, so tvalid never drops while a tick waits for tready.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed
    tick_t t;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap        <= send_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (ticks_to_send.size() != 0) begin
        t = ticks_to_send.pop_front();
        {s_axis_tuser_i, s_axis_tdata_i} <= t;
        s_axis_tvalid_i <= 1'b1;
        if (sender_idling && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 19);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure on the result side, plus one long hold
  // that starts once enough ticks have gone in, so both stages fill and the
  // block refuses further input.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (!hold_done && items_accepted >= hold_at) begin
      m_axis_tready_i <= 1'b0;
      hold_done       <= 1'b1;
      hold_left       <= 120;
    end else if (recv_gap > 0) begin
      m_axis_tready_i <= 1'b0;
      recv_gap        <= recv_gap - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (recv_idling && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 19);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, predicts the result of an accepted input
  // transaction and checks a completed result transaction against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    status_t want;
    status_t got;
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_status.push_back(supervise_tick({s_axis_tuser_i, s_axis_tdata_i}));
        items_accepted++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (expected_status.size() == 0) begin
          $error("result 0x%h arrived with none expected", m_axis_tdata_o);
          failures++;
        end else begin
          want = expected_status.pop_front();
          check_field("duty", want.duty, got.duty);
          check_field("coil_on", 7'(want.coil_on), 7'(got.coil_on));
          check_field("fire_pulse", 7'(want.fire_pulse), 7'(got.fire_pulse));
          check_field("overtemp", 7'(want.overtemp), 7'(got.overtemp));
          check_field("pan_found", 7'(want.pan_found), 7'(got.pan_found));
          check_field("freq_found", 7'(want.freq_found), 7'(got.freq_found));
          check_field("phase", 7'(want.phase), 7'(got.phase));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Register defaults and cleared channels, as after reset.
    reg_copy[ipdps_pkg::CFG_COIL_LIMIT]   = 10'd800;
    reg_copy[ipdps_pkg::CFG_SWITCH_LIMIT] = 10'd800;
    reg_copy[ipdps_pkg::CFG_COIL_HYST]    = 10'd50;
    reg_copy[ipdps_pkg::CFG_SWITCH_HYST]  = 10'd50;
    reg_copy[ipdps_pkg::CFG_LOW_CUR_LIM]  = 10'd3;
    reg_copy[ipdps_pkg::CFG_PAN_MIN]      = 10'd3;
    reg_copy[ipdps_pkg::CFG_PAN_MAX]      = 10'd20;
    reg_copy[ipdps_pkg::CFG_FREQ_MIN]     = 10'd3;
    coil_state[0] = '0;
    coil_state[1] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    sender_idling = 1'b1;
    recv_idling   = 1'b1;

    // Directed part with the reset defaults. Channel 0 first idles with the
    // coil off, then sees overtemperature set from both sensors at full
    // scale and cleared again with both at zero, and proves its current.
    ticks_to_send.push_back(make_tick(SLOW_TICK, 1'b0, 1'b0, 7'd0, 10'd0, 10'd0,
                                      8'd0, 8'd0));
    ticks_to_send.push_back(make_tick(FAST_TICK, 1'b0, 1'b1, 7'd127, 10'd1023, 10'd1023,
                                      8'd255, 8'd255));
    ticks_to_send.push_back(make_tick(FAST_TICK, 1'b0, 1'b1, 7'd0, 10'd0, 10'd0,
                                      8'd0, 8'd0));
    repeat (2) ticks_to_send.push_back(make_tick(SLOW_TICK, 1'b0, 1'b1, 7'd50, 10'd0,
                                                 10'd0, 8'd0, 8'd0));
    ticks_to_send.push_back(make_tick(SLOW_TICK, 1'b0, 1'b1, 7'd50, 10'd0, 10'd0,
                                      8'd255, 8'd0));
    // Channel 1 starts, then runs out of current tolerance and takes the probe.
    repeat (6) ticks_to_send.push_back(make_tick(SLOW_TICK, 1'b1, 1'b1, 7'd50, 10'd0,
                                                 10'd0, 8'd0, 8'd0));
    // Channel 0 loses current while channel 1 probes, so it is locked out.
    repeat (6) ticks_to_send.push_back(make_tick(SLOW_TICK, 1'b0, 1'b1, 7'd50, 10'd0,
                                                 10'd0, 8'd0, 8'd0));
    // Channel 1 walks the pan and frequency windows with a counted pan.
    repeat (7) ticks_to_send.push_back(make_tick(SLOW_TICK, 1'b1, 1'b1, 7'd50, 10'd0,
                                                 10'd0, 8'd0, 8'd10));
    drain_block();

    queue_random(200);
    drain_block();

    // Widest windows: never hot, no current tolerance, any count passes.
    write_all_regs(10'd1023, 10'd1023, 10'd0, 10'd0, 8'd0, 8'd0, 8'd255, 8'd0);
    queue_random(200);
    drain_block();

    // Narrowest windows: hot latches for good, empty pan window.
    write_all_regs(10'd0, 10'd0, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd0, 8'd255);
    queue_random(80);
    drain_block();

    // Mid-range settings, with one long stall on the result side.
    write_all_regs(10'($urandom_range(400, 900)), 10'($urandom_range(400, 900)),
                   10'($urandom_range(0, 200)), 10'($urandom_range(0, 200)),
                   8'($urandom_range(0, 6)), 8'($urandom_range(0, 10)),
                   8'($urandom_range(5, 40)), 8'($urandom_range(0, 10)));
    hold_at = items_accepted + 40;
    queue_random(250);
    drain_block();

    // Back to the defaults, running at full rate on both sides.
    write_all_regs(10'd800, 10'd800, 10'd50, 10'd50, 8'd3, 8'd3, 8'd20, 8'd3);
    sender_idling = 1'b0;
    recv_idling   = 1'b0;
    queue_random(200);
    drain_block();

    if (failures == 0) begin
      $display("induction_pan_detect_power_sequencer_test: done, clean");
    end else begin
      $display("induction_pan_detect_power_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== induction_pan_detect_power_sequencer.f =====
rtl/ipdps_pkg.sv
rtl/induction_pan_detect_power_sequencer.sv
tb/induction_pan_detect_power_sequencer_test.sv
